@@ rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texture sampler
// Fixed widths of the request and result fields, register indexes, stage
// payloads and the size clamp used by the configuration registers.
// ----------------------------------------------------------------------------
package bts_pkg;

	// Coordinate format: unsigned Q1.16
	localparam int COORD_FRAC_BITS = 16;
	localparam int COORD_W         = COORD_FRAC_BITS + 1;
	localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;

	// Texture geometry
	localparam int SIZE_W   = 9;
	localparam int POS_W    = 8;
	localparam int INDEX_W  = 16;
	localparam int ROW_W    = 16;
	localparam int TEXEL_W  = 32;
	localparam int BYTE_W   = 8;
	localparam int NUM_CH   = 4;
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(256);
	localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);

	// Arithmetic widths
	localparam int SCALED_W  = COORD_W + POS_W;
	localparam int WGT_W     = 2 * COORD_FRAC_BITS + 1;
	localparam int ACC_W     = 2 * COORD_FRAC_BITS + BYTE_W;
	localparam int CHAN_W    = 16;
	localparam int OUT_SHIFT = 2 * COORD_FRAC_BITS - 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HEIGHT = 2'd1
	} cfg_reg_t;

	// Request function codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Neighbour fetch order of one sample
	typedef enum logic [1:0] {
		TAP_00 = 2'd0,
		TAP_10 = 2'd1,
		TAP_01 = 2'd2,
		TAP_11 = 2'd3
	} tap_t;

	// Request after coordinate split
	typedef struct packed {
		logic                     func;
		logic [INDEX_W-1:0]       index;
		logic [TEXEL_W-1:0]       rgba;
		logic [POS_W-1:0]         x0;
		logic [COORD_FRAC_BITS-1:0] a;
		logic [POS_W-1:0]         y0;
		logic [COORD_FRAC_BITS-1:0] b;
	} split_t;

	// Request at the memory port
	typedef struct packed {
		logic                     func;
		logic [INDEX_W-1:0]       index;
		logic [TEXEL_W-1:0]       rgba;
		logic [POS_W-1:0]         x0;
		logic [POS_W-1:0]         x1;
		logic [ROW_W-1:0]         row0;
		logic [ROW_W-1:0]         row1;
		logic [COORD_FRAC_BITS-1:0] a;
		logic [COORD_FRAC_BITS-1:0] b;
	} fetch_t;

	// Map a size register write onto 1..256
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = SIZE_W'(s);
		if (r == '0) begin
			r = SIZE_MIN;
		end else if (r > SIZE_MAX) begin
			r = SIZE_MAX;
		end
		return r;
	endfunction

endpackage

@@ rtl/bilinear_texture_sampler.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler: RGBA8 texture store with bilinear sampling
// Write requests fill one texel of a single-port texture memory; sample
// requests fetch four neighbours and return each channel in 8.8 fixed point.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -----------------------------------
//  in        sink       in_valid / in_stall    func, texel_index, texel_rgba,
//                                              u_coord, v_coord
//  out       source     out_valid / out_stall  red_out, green_out, blue_out,
//                                              alpha_out
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A sample holds the texture memory port for one read per neighbour; a write
//  holds it for a single access. The single memory port sets the rate: a new
//  sample starts only after the last one's four reads, one write per cycle
//  while no stalled sample holds the port. A result passes the stage 1, stage 2,
//  read data, stage 4 and result registers.
//  Reset clears control state only; the texture store is undefined until
//  written and has no clearing pass. cfg_ready is always high.
//  A stalled result holds the output register; requests keep being accepted
//  until the pipeline behind the memory port fills.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler #(
	parameter int MAX_TEXELS = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               func,
	input  logic [15:0]                        texel_index,
	input  logic [31:0]                        texel_rgba,
	input  logic [16:0]                        u_coord,
	input  logic [16:0]                        v_coord,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [15:0]                        red_out,
	output logic [15:0]                        green_out,
	output logic [15:0]                        blue_out,
	output logic [15:0]                        alpha_out,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ADDR_W = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	logic [bts_pkg::SIZE_W-1:0]  width_q, height_q;
	logic [bts_pkg::POS_W-1:0]   wm1, hm1;

	logic                        valid_s1;
	bts_pkg::split_t             item_s1;
	bts_pkg::split_t             split_next;
	logic [bts_pkg::COORD_W-1:0] u_sat, v_sat;
	logic [bts_pkg::SCALED_W-1:0] u_scaled, v_scaled;

	logic                        valid_s2;
	bts_pkg::fetch_t             item_s2;
	bts_pkg::fetch_t             fetch_next;
	logic [bts_pkg::SIZE_W-1:0]  x0_inc, y0_inc;
	logic [bts_pkg::POS_W-1:0]   y1_next;

	bts_pkg::tap_t               phase_q;
	bts_pkg::tap_t               phase_next;
	logic [bts_pkg::POS_W-1:0]   tap_x;
	logic [bts_pkg::ROW_W-1:0]   tap_row;
	logic [bts_pkg::COORD_W-1:0] tap_fx, tap_fy, na, nb;
	logic [bts_pkg::ROW_W-1:0]   rd_addr;
	logic                        rd_oob;
	logic                        rd_en, wr_en;

	logic                        m_done, s2_free, s1_free;
	logic                        s3_go, s4_go, out_free;

	logic [bts_pkg::TEXEL_W-1:0] tex_mem [MAX_TEXELS];
	logic [bts_pkg::TEXEL_W-1:0] rd_data_q;

	logic                        valid_s3;
	logic [bts_pkg::WGT_W-1:0]   wgt_s3;
	logic                        oob_s3, first_s3, last_s3;
	logic [bts_pkg::TEXEL_W-1:0] texel_s3;
	logic [bts_pkg::ACC_W-1:0]   prod_next [bts_pkg::NUM_CH];

	logic                        valid_s4;
	logic                        first_s4, last_s4;
	logic [bts_pkg::ACC_W-1:0]   prod_s4 [bts_pkg::NUM_CH];
	logic [bts_pkg::ACC_W-1:0]   acc_q   [bts_pkg::NUM_CH];
	logic [bts_pkg::ACC_W-1:0]   acc_sum [bts_pkg::NUM_CH];

	logic                        out_valid_q;
	logic [bts_pkg::CHAN_W-1:0]  chan_q  [bts_pkg::NUM_CH];

	// ------------------------------------------------------------------
	// Configuration registers: store the size already clamped to 1..256
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bts_pkg::SIZE_MAX;
			height_q <= bts_pkg::SIZE_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (bts_pkg::cfg_reg_t'(cfg_index))
				bts_pkg::REG_TEX_WIDTH: begin
					width_q <= bts_pkg::clamp_size(cfg_data);
				end
				bts_pkg::REG_TEX_HEIGHT: begin
					height_q <= bts_pkg::clamp_size(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign wm1 = bts_pkg::POS_W'(width_q - bts_pkg::SIZE_W'(1));
	assign hm1 = bts_pkg::POS_W'(height_q - bts_pkg::SIZE_W'(1));

	// ------------------------------------------------------------------
	// Handshake chain, from the result register back to the request side
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign s4_go    = !valid_s4 || !last_s4 || out_free;
	assign s3_go    = !valid_s3 || s4_go;
	assign rd_en    = valid_s2 && (item_s2.func == bts_pkg::FUNC_SAMPLE) && s3_go;
	assign m_done   = valid_s2 && ((item_s2.func == bts_pkg::FUNC_WRITE) ||
	                               (s3_go && (phase_q == bts_pkg::TAP_11)));
	assign s2_free  = !valid_s2 || m_done;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;

	// ------------------------------------------------------------------
	// Stage 1: saturate coordinates, scale by size minus one, split
	// ------------------------------------------------------------------
	always_comb begin
		u_sat    = (u_coord > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : u_coord;
		v_sat    = (v_coord > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE : v_coord;
		u_scaled = bts_pkg::SCALED_W'(u_sat) * bts_pkg::SCALED_W'(wm1);
		v_scaled = bts_pkg::SCALED_W'(v_sat) * bts_pkg::SCALED_W'(hm1);

		split_next.func  = func;
		split_next.index = texel_index;
		split_next.rgba  = texel_rgba;
		split_next.x0    = u_scaled[bts_pkg::COORD_FRAC_BITS +: bts_pkg::POS_W];
		split_next.a     = u_scaled[bts_pkg::COORD_FRAC_BITS-1:0];
		split_next.y0    = v_scaled[bts_pkg::COORD_FRAC_BITS +: bts_pkg::POS_W];
		split_next.b     = v_scaled[bts_pkg::COORD_FRAC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			item_s1 <= split_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: clamp right and bottom neighbours, form row base addresses
	// ------------------------------------------------------------------
	always_comb begin
		x0_inc  = bts_pkg::SIZE_W'(item_s1.x0) + bts_pkg::SIZE_W'(1);
		y0_inc  = bts_pkg::SIZE_W'(item_s1.y0) + bts_pkg::SIZE_W'(1);
		y1_next = (y0_inc < height_q) ? y0_inc[bts_pkg::POS_W-1:0] : hm1;

		fetch_next.func  = item_s1.func;
		fetch_next.index = item_s1.index;
		fetch_next.rgba  = item_s1.rgba;
		fetch_next.x0    = item_s1.x0;
		fetch_next.x1    = (x0_inc < width_q) ? x0_inc[bts_pkg::POS_W-1:0] : wm1;
		fetch_next.row0  = bts_pkg::ROW_W'(item_s1.y0) * bts_pkg::ROW_W'(width_q);
		fetch_next.row1  = bts_pkg::ROW_W'(y1_next) * bts_pkg::ROW_W'(width_q);
		fetch_next.a     = item_s1.a;
		fetch_next.b     = item_s1.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			item_s2 <= fetch_next;
		end
	end

	// ------------------------------------------------------------------
	// Memory port sequencer: one neighbour per cycle while stage 3 can advance, weight per tap
	// ------------------------------------------------------------------
	always_comb begin
		na = bts_pkg::COORD_ONE - bts_pkg::COORD_W'(item_s2.a);
		nb = bts_pkg::COORD_ONE - bts_pkg::COORD_W'(item_s2.b);
		case (phase_q)
			bts_pkg::TAP_00: begin
				tap_x      = item_s2.x0;
				tap_row    = item_s2.row0;
				tap_fx     = na;
				tap_fy     = nb;
				phase_next = bts_pkg::TAP_10;
			end
			bts_pkg::TAP_10: begin
				tap_x      = item_s2.x1;
				tap_row    = item_s2.row0;
				tap_fx     = bts_pkg::COORD_W'(item_s2.a);
				tap_fy     = nb;
				phase_next = bts_pkg::TAP_01;
			end
			bts_pkg::TAP_01: begin
				tap_x      = item_s2.x0;
				tap_row    = item_s2.row1;
				tap_fx     = na;
				tap_fy     = bts_pkg::COORD_W'(item_s2.b);
				phase_next = bts_pkg::TAP_11;
			end
			bts_pkg::TAP_11: begin
				tap_x      = item_s2.x1;
				tap_row    = item_s2.row1;
				tap_fx     = bts_pkg::COORD_W'(item_s2.a);
				tap_fy     = bts_pkg::COORD_W'(item_s2.b);
				phase_next = bts_pkg::TAP_00;
			end
			default: begin
				tap_x      = item_s2.x0;
				tap_row    = item_s2.row0;
				tap_fx     = na;
				tap_fy     = nb;
				phase_next = bts_pkg::TAP_00;
			end
		endcase
		rd_addr = tap_row + bts_pkg::ROW_W'(tap_x);
		rd_oob  = 32'(rd_addr) >= 32'(MAX_TEXELS);
	end

	assign wr_en = valid_s2 && (item_s2.func == bts_pkg::FUNC_WRITE) &&
	               (32'(item_s2.index) < 32'(MAX_TEXELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bts_pkg::TAP_00;
		end else if (rd_en) begin
			phase_q <= phase_next;
		end
	end

	// Texture memory: single port, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tex_mem[ADDR_W'(item_s2.index)] <= item_s2.rgba;
		end
		if (rd_en) begin
			rd_data_q <= tex_mem[ADDR_W'(rd_addr)];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: neighbour weight beside the read data, per-channel products
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_go) begin
			valid_s3 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			wgt_s3   <= bts_pkg::WGT_W'(tap_fx) * bts_pkg::WGT_W'(tap_fy);
			oob_s3   <= rd_oob;
			first_s3 <= (phase_q == bts_pkg::TAP_00);
			last_s3  <= (phase_q == bts_pkg::TAP_11);
		end
	end

	// Drop fetches outside the store to zero
	always_comb begin
		texel_s3 = oob_s3 ? '0 : rd_data_q;
		for (int ch = 0; ch < bts_pkg::NUM_CH; ch++) begin
			prod_next[ch] = bts_pkg::ACC_W'(wgt_s3) *
			                bts_pkg::ACC_W'(texel_s3[ch*bts_pkg::BYTE_W +: bts_pkg::BYTE_W]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: accumulate four weighted neighbours per channel
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_go) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_go && valid_s3) begin
			prod_s4  <= prod_next;
			first_s4 <= first_s3;
			last_s4  <= last_s3;
		end
	end

	always_comb begin
		for (int ch = 0; ch < bts_pkg::NUM_CH; ch++) begin
			acc_sum[ch] = (first_s4 ? '0 : acc_q[ch]) + prod_s4[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && s4_go) begin
			acc_q <= acc_sum;
		end
	end

	// ------------------------------------------------------------------
	// Result register: hold while stalled, load on the last neighbour
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s4 && last_s4 && s4_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && last_s4 && s4_go) begin
			for (int ch = 0; ch < bts_pkg::NUM_CH; ch++) begin
				chan_q[ch] <= acc_sum[ch][bts_pkg::OUT_SHIFT +: bts_pkg::CHAN_W];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = chan_q[0];
	assign green_out = chan_q[1];
	assign blue_out  = chan_q[2];
	assign alpha_out = chan_q[3];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// The single memory port never reads and writes in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("texture memory read and write collide");

	// A write request never sits at the port in the middle of a sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (item_s2.func == bts_pkg::FUNC_WRITE)) |->
			(phase_q == bts_pkg::TAP_00))
		else $error("write request at memory port with fetch phase open");

	// Read data held by a stalled stage 3 must not be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !s4_go) |=> $stable(rd_data_q))
		else $error("read data changed under a stalled stage");

	// A result only appears after the last neighbour was accumulated
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s4 && last_s4))
		else $error("result raised without a completed sample");

endmodule
